// ===== rtl/raster_cell_map_to_triangles_assert.svh =====
// assertion macros shared by the checker of the cell map mesher
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef RASTER_CELL_MAP_TO_TRIANGLES_ASSERT_SVH
`define RASTER_CELL_MAP_TO_TRIANGLES_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcm_pkg.sv =====
// shared types, constants and control structs of the cell map mesher
// no dependencies
package rcm_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int SCALE_W = 23;
  localparam int COORD_W = 24;
  localparam int IDX_W   = 20;
  localparam int VIX_W   = IDX_W + 1;
  localparam int W_W     = 10;
  localparam int DD_W    = 9;
  localparam int Q_W     = COORD_W;
  localparam int FRAC_DROP = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [PIX_W-1:0] PIX_THRESH = 8'd16;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CRD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CCL_W  = ($clog2(MAX_COLUMNS + 1) > SIZE_W) ? $clog2(MAX_COLUMNS + 1) : SIZE_W;
  localparam int RCL_W  = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
  localparam int SUM_W  = CRD_W + W_W;
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam int DVD_W  = PROD_W - FRAC_DROP;
  localparam int DC_W   = (DVD_W > W_W + Q_W) ? DVD_W : W_W + Q_W;
  localparam int QC_W   = $clog2(Q_W);
  localparam int VRA_W  = $clog2(2 * MAX_COLUMNS);

  localparam logic [SIZE_W-1:0]  COLS_RESET  = 11'd256;
  localparam logic [SIZE_W-1:0]  ROWS_RESET  = 11'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 23'd25600;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0]  map_columns;
    logic [SIZE_W-1:0]  map_rows;
    logic [SCALE_W-1:0] mm_per_cell;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_COLS,
    REG_ROWS,
    REG_SCALE
  } reg_idx_t;

  typedef enum logic {
    AX_X,
    AX_Y
  } axis_t;

  typedef enum logic [1:0] {
    RD_V,
    RD_N,
    RD_B
  } rd_sel_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_V,
    CAP_N,
    CAP_B
  } cap_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PIX,
    S_WIN,
    S_VSEL,
    S_SUMX,
    S_MULX,
    S_DIVX,
    S_WAITX,
    S_SUMY,
    S_MULY,
    S_DIVY,
    S_WAITY,
    S_WRV,
    S_RDV,
    S_RDN,
    S_RDB,
    S_CAPB,
    S_SEL,
    S_EMIT,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       window;
    logic       sum_en;
    logic       mul_en;
    logic       div_start;
    logic       store_en;
    axis_t      axis;
    logic       wr_vtx;
    rd_sel_t    rd_sel;
    cap_t       cap;
    logic       load_out;
    logic [1:0] ridx;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic       win;
    logic       tri_ok;
    logic       vtx;
    logic       div_busy;
    logic [1:0] total;
  } stat_t;

endpackage

// ===== rtl/rcm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rcm_div.sv =====
// restoring divider, one quotient bit per cycle, saturating quotient
// depends on rcm_pkg
module rcm_div
  import rcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [W_W-1:0]   divisor,
  output logic             busy,
  output logic [Q_W-1:0]   quotient
);

  logic              busy_r;
  logic [QC_W-1:0]   cnt_r;
  logic [W_W-1:0]    rem_r;
  logic [W_W-1:0]    dvs_r;
  logic [Q_W-1:0]    lo_r;
  logic [Q_W-1:0]    q_r;
  logic [DC_W-1:0]   dvd_ext;
  logic [DC_W-1:0]   top_ext;
  logic              sat;
  logic [W_W:0]      trial;
  logic              ge;
  logic [W_W-1:0]    rem_nxt;

  assign dvd_ext = DC_W'(dividend);
  assign top_ext = dvd_ext >> Q_W;
  // quotient would not fit in the result width
  assign sat     = dvd_ext >= (DC_W'(divisor) << Q_W);

  assign trial   = {rem_r, lo_r[Q_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? W_W'(trial - {1'b0, dvs_r}) : trial[W_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= !sat;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == QC_W'(Q_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= top_ext[W_W-1:0];
      lo_r  <= dividend[Q_W-1:0];
      dvs_r <= divisor;
      q_r   <= sat ? '1 : '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== rtl/rcm_datapath.sv =====
// datapath: counters, line buffers, centroid arithmetic, triangle pattern, result register
// depends on rcm_pkg, rcm_ram, rcm_div
module rcm_datapath
  import rcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               in_frame_start,
  output logic               out_kind,
  output logic [COORD_W-1:0] out_coord_x,
  output logic [COORD_W-1:0] out_coord_y,
  output logic [IDX_W-1:0]   out_corner_a,
  output logic [IDX_W-1:0]   out_corner_b,
  output logic [IDX_W-1:0]   out_corner_c,
  output logic               out_last
);

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } tri_t;

  function automatic logic [VRA_W-1:0] vrow_addr(input logic hi, input logic [COL_W-1:0] col);
    logic [VRA_W-1:0] base;
    base = hi ? VRA_W'(MAX_COLUMNS) : '0;
    return base + VRA_W'(col);
  endfunction

  // clamped sizes
  logic [CCL_W-1:0] cols_raw, cols_c;
  logic [RCL_W-1:0] rows_raw, rows_c;

  assign cols_raw = CCL_W'(cfg.map_columns);
  assign rows_raw = RCL_W'(cfg.map_rows);
  assign cols_c = (cols_raw < CCL_W'(2)) ? CCL_W'(2) :
                  (cols_raw > CCL_W'(MAX_COLUMNS)) ? CCL_W'(MAX_COLUMNS) : cols_raw;
  assign rows_c = (rows_raw < RCL_W'(2)) ? RCL_W'(2) :
                  (rows_raw > RCL_W'(MAX_ROWS)) ? RCL_W'(MAX_ROWS) : rows_raw;

  logic [COL_W-1:0] col_r, c_acc, x;
  logic [ROW_W-1:0] row_r, r_acc, y;
  logic [IDX_W-1:0] vcnt_r;
  logic [PIX_W-1:0] px_r, left_r, ul_r, prd;

  assign c_acc = in_frame_start ? '0 : col_r;
  assign r_acc = in_frame_start ? '0 : row_r;
  assign x = COL_W'(col_r - 1'b1);
  assign y = ROW_W'(row_r - 1'b1);

  assign stat.win = (col_r != '0) && (row_r != '0) &&
                    (CCL_W'(col_r) < cols_c) && (RCL_W'(row_r) < rows_c);
  assign stat.tri_ok = stat.win && (col_r > COL_W'(1)) && (row_r > ROW_W'(1));

  // window pixels
  logic [PIX_W-1:0] m_tl, m_tr, m_bl, m_br;
  logic [W_W-1:0]   w_sum, w_r;
  logic [DD_W-1:0]  dx_sum, dy_sum, dx_r, dy_r;
  logic [2:0]       n_pass;
  logic             n2_r;

  always_comb begin
    m_tl = (ul_r   > PIX_THRESH) ? ul_r   : '0;
    m_tr = (prd    > PIX_THRESH) ? prd    : '0;
    m_bl = (left_r > PIX_THRESH) ? left_r : '0;
    m_br = (px_r   > PIX_THRESH) ? px_r   : '0;
    n_pass = 3'(ul_r > PIX_THRESH) + 3'(prd > PIX_THRESH) +
             3'(left_r > PIX_THRESH) + 3'(px_r > PIX_THRESH);
    w_sum  = W_W'(m_tl) + W_W'(m_tr) + W_W'(m_bl) + W_W'(m_br);
    dx_sum = DD_W'(m_br) + DD_W'(m_tr);
    dy_sum = DD_W'(m_bl) + DD_W'(m_br);
  end

  assign stat.vtx = stat.win && n2_r;

  // counters and neighbour pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      vcnt_r <= '0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      if (cmd.accept) begin
        col_r <= c_acc;
        row_r <= r_acc;
        if (c_acc == '0 && r_acc == '0) begin
          vcnt_r <= '0;
        end
      end
      if (cmd.window) begin
        ul_r   <= prd;
        left_r <= px_r;
      end
      if (cmd.wr_vtx && n2_r) begin
        vcnt_r <= vcnt_r + 1'b1;
      end
      if (cmd.advance) begin
        if (CCL_W'(col_r) + CCL_W'(1) >= cols_c) begin
          col_r <= '0;
          row_r <= (RCL_W'(row_r) + RCL_W'(1) >= rows_c) ? '0 : ROW_W'(row_r + 1'b1);
        end else begin
          col_r <= COL_W'(col_r + 1'b1);
        end
      end
    end
  end

  rcm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLUMNS)) u_prow (
    .clk   (clk),
    .we    (cmd.window),
    .waddr (col_r),
    .wdata (px_r),
    .raddr (col_r),
    .rdata (prd)
  );

  // centroid arithmetic
  logic [CRD_W-1:0]  coord;
  logic [DD_W-1:0]   dd;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]    quo, qx_r, qy_r;

  assign coord = (cmd.axis == AX_X) ? CRD_W'(x) : CRD_W'(y);
  assign dd    = (cmd.axis == AX_X) ? dx_r : dy_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r <= in_pixel;
    end
    if (cmd.window) begin
      w_r  <= w_sum;
      dx_r <= dx_sum;
      dy_r <= dy_sum;
      n2_r <= n_pass >= 3'd2;
    end
    if (cmd.sum_en) begin
      sum_r <= SUM_W'(coord) * SUM_W'(w_r) + SUM_W'(dd);
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(cfg.mm_per_cell);
    end
    if (cmd.store_en) begin
      if (cmd.axis == AX_X) begin
        qx_r <= quo;
      end else begin
        qy_r <= quo;
      end
    end
  end

  rcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r[PROD_W-1:FRAC_DROP]),
    .divisor  (w_r),
    .busy     (stat.div_busy),
    .quotient (quo)
  );

  // vertex index rows
  logic [VRA_W-1:0] v_waddr, v_raddr;
  logic [VIX_W-1:0] entry, vrd, entry_r, v_r, n_r, b_r;

  assign entry   = {n2_r, vcnt_r};
  assign v_waddr = vrow_addr(y[0], x);

  always_comb begin
    case (cmd.rd_sel)
      RD_V:    v_raddr = vrow_addr(!y[0], COL_W'(x - 1'b1));
      RD_N:    v_raddr = vrow_addr(!y[0], x);
      RD_B:    v_raddr = vrow_addr(y[0], COL_W'(x - 1'b1));
      default: v_raddr = vrow_addr(y[0], x);
    endcase
  end

  rcm_ram #(.WIDTH(VIX_W), .DEPTH(2 * MAX_COLUMNS)) u_vrow (
    .clk   (clk),
    .we    (cmd.wr_vtx),
    .waddr (v_waddr),
    .wdata (entry),
    .raddr (v_raddr),
    .rdata (vrd)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr_vtx) begin
      entry_r <= entry;
    end
    case (cmd.cap)
      CAP_V:   v_r <= vrd;
      CAP_N:   n_r <= vrd;
      CAP_B:   b_r <= vrd;
      default: ;
    endcase
  end

  // corner pattern of the cell
  logic hv, hn, hb, hbn;
  logic [1:0] tcnt, ntri;
  tri_t t0, t1;

  always_comb begin
    hv  = v_r[IDX_W];
    hn  = n_r[IDX_W];
    hb  = b_r[IDX_W];
    hbn = entry_r[IDX_W];
    tcnt = 2'd0;
    t0 = '0;
    t1 = '0;
    if (hv && hn && hb) begin
      t0 = '{v_r[IDX_W-1:0], n_r[IDX_W-1:0], b_r[IDX_W-1:0]};
      t1 = '{n_r[IDX_W-1:0], entry_r[IDX_W-1:0], b_r[IDX_W-1:0]};
      tcnt = hbn ? 2'd2 : 2'd1;
    end else if (hv && hn && hbn) begin
      t0 = '{v_r[IDX_W-1:0], n_r[IDX_W-1:0], entry_r[IDX_W-1:0]};
      tcnt = 2'd1;
    end else if (hv && !hn && hb && hbn) begin
      t0 = '{v_r[IDX_W-1:0], b_r[IDX_W-1:0], entry_r[IDX_W-1:0]};
      tcnt = 2'd1;
    end else if (!hv && hn && hb && hbn) begin
      t0 = '{n_r[IDX_W-1:0], entry_r[IDX_W-1:0], b_r[IDX_W-1:0]};
      tcnt = 2'd1;
    end
  end

  assign ntri       = stat.tri_ok ? tcnt : 2'd0;
  assign stat.total = {1'b0, stat.vtx} + ntri;

  // result register
  logic [1:0] tsel;
  tri_t       tsl;

  assign tsel = cmd.ridx - {1'b0, stat.vtx};
  assign tsl  = tsel[0] ? t1 : t0;

  logic               kind_r, last_r;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [IDX_W-1:0]   oa_r, ob_r, oc_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      last_r <= cmd.ridx == (stat.total - 2'd1);
      if (stat.vtx && cmd.ridx == 2'd0) begin
        kind_r <= KIND_VERTEX;
        ox_r   <= qx_r;
        oy_r   <= qy_r;
        oa_r   <= '0;
        ob_r   <= '0;
        oc_r   <= '0;
      end else begin
        kind_r <= KIND_TRI;
        ox_r   <= '0;
        oy_r   <= '0;
        oa_r   <= tsl.a;
        ob_r   <= tsl.b;
        oc_r   <= tsl.c;
      end
    end
  end

  assign out_kind     = kind_r;
  assign out_coord_x  = ox_r;
  assign out_coord_y  = oy_r;
  assign out_corner_a = oa_r;
  assign out_corner_b = ob_r;
  assign out_corner_c = oc_r;
  assign out_last     = last_r;

endmodule

// ===== rtl/rcm_ctrl.sv =====
// controller state machine sequencing one request through the datapath
// depends on rcm_pkg
module rcm_ctrl
  import rcm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] k_r;
  logic       last_res;

  assign last_res = k_r == (stat.total - 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SEL) begin
        k_r <= '0;
      end else if (state_r == S_WAIT && out_ready) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_PIX;
      S_PIX:   state_nxt = S_WIN;
      S_WIN:   state_nxt = S_VSEL;
      S_VSEL: begin
        if (!stat.win) state_nxt = S_DONE;
        else if (stat.vtx) state_nxt = S_SUMX;
        else state_nxt = S_WRV;
      end
      S_SUMX:  state_nxt = S_MULX;
      S_MULX:  state_nxt = S_DIVX;
      S_DIVX:  state_nxt = S_WAITX;
      S_WAITX: if (!stat.div_busy) state_nxt = S_SUMY;
      S_SUMY:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_DIVY;
      S_DIVY:  state_nxt = S_WAITY;
      S_WAITY: if (!stat.div_busy) state_nxt = S_WRV;
      S_WRV:   state_nxt = stat.tri_ok ? S_RDV : S_SEL;
      S_RDV:   state_nxt = S_RDN;
      S_RDN:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_CAPB;
      S_CAPB:  state_nxt = S_SEL;
      S_SEL:   state_nxt = (stat.total == 2'd0) ? S_DONE : S_EMIT;
      S_EMIT:  state_nxt = S_WAIT;
      S_WAIT:  if (out_ready) state_nxt = last_res ? S_DONE : S_EMIT;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.ridx  = k_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_WIN:   cmd.window = 1'b1;
      S_SUMX:  cmd.sum_en = 1'b1;
      S_MULX:  cmd.mul_en = 1'b1;
      S_DIVX:  cmd.div_start = 1'b1;
      S_WAITX: cmd.store_en = !stat.div_busy;
      S_SUMY: begin
        cmd.sum_en = 1'b1;
        cmd.axis   = AX_Y;
      end
      S_MULY: begin
        cmd.mul_en = 1'b1;
        cmd.axis   = AX_Y;
      end
      S_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.axis      = AX_Y;
      end
      S_WAITY: begin
        cmd.store_en = !stat.div_busy;
        cmd.axis     = AX_Y;
      end
      S_WRV:   cmd.wr_vtx = 1'b1;
      S_RDV:   cmd.rd_sel = RD_V;
      S_RDN: begin
        cmd.rd_sel = RD_N;
        cmd.cap    = CAP_V;
      end
      S_RDB: begin
        cmd.rd_sel = RD_B;
        cmd.cap    = CAP_N;
      end
      S_CAPB:  cmd.cap = CAP_B;
      S_EMIT:  cmd.load_out = 1'b1;
      S_WAIT:  out_valid = 1'b1;
      S_DONE:  cmd.advance = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/raster_cell_map_to_triangles.sv =====
// Cell map mesher: takes gray cells in raster order, one request at a time, and for
// each 2x2 window with two or more pixels above 16 emits a vertex (weighted centroid
// scaled by mm_per_cell, unsigned with 8 fraction bits, saturating), then the zero to
// two triangles of the cell one row up and one column left. Requests are handled one
// after another; a new request is taken only after the last result of the previous
// one has been accepted. A vertex works out its two centroid quotients in turn on the
// shared restoring divider (a quotient that saturates skips the divide steps).
// frame_start puts a cell at row 0, column 0. Map sizes are clamped to 2..1024 where
// they are used. Line buffer contents are undefined after reset until the first row
// has passed, so no clearing pass is needed.
// depends on rcm_pkg, rcm_ctrl, rcm_datapath
module raster_cell_map_to_triangles
  import rcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               in_frame_start,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [COORD_W-1:0] out_coord_x,
  output logic [COORD_W-1:0] out_coord_y,
  output logic [IDX_W-1:0]   out_corner_a,
  output logic [IDX_W-1:0]   out_corner_b,
  output logic [IDX_W-1:0]   out_corner_c,
  output logic               out_last
);

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  cmd_t     cmd;
  stat_t    stat;

  // registers sit on word addresses, so the index is paddr above the byte bits
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  // register writes complete in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_columns <= COLS_RESET;
      cfg_r.map_rows    <= ROWS_RESET;
      cfg_r.mm_per_cell <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_COLS:  cfg_r.map_columns <= pwdata[SIZE_W-1:0];
        REG_ROWS:  cfg_r.map_rows    <= pwdata[SIZE_W-1:0];
        REG_SCALE: cfg_r.mm_per_cell <= pwdata[SCALE_W-1:0];
        default:   ;
      endcase
    end
  end

  // read back, unused addresses return zero
  always_comb begin
    case (reg_sel)
      REG_COLS:  prdata = PDATA_W'(cfg_r.map_columns);
      REG_ROWS:  prdata = PDATA_W'(cfg_r.map_rows);
      REG_SCALE: prdata = PDATA_W'(cfg_r.mm_per_cell);
      default:   prdata = '0;
    endcase
  end

  // sequencer: one request in flight, results released one at a time
  rcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // counters, line buffers, centroid and triangle logic, result register
  rcm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_kind       (out_kind),
    .out_coord_x    (out_coord_x),
    .out_coord_y    (out_coord_y),
    .out_corner_a   (out_corner_a),
    .out_corner_b   (out_corner_b),
    .out_corner_c   (out_corner_c),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/rcm_checker.sv =====
// port level checks of the cell map mesher, bound to the top level
// depends on rcm_pkg and raster_cell_map_to_triangles_assert.svh
`include "raster_cell_map_to_triangles_assert.svh"

module rcm_checker
  import rcm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_kind,
  input logic [COORD_W-1:0] out_coord_x,
  input logic [COORD_W-1:0] out_coord_y,
  input logic [IDX_W-1:0]   out_corner_a,
  input logic [IDX_W-1:0]   out_corner_b,
  input logic [IDX_W-1:0]   out_corner_c,
  input logic               out_last
);

  `RCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_coord_x) && $stable(out_coord_y) && $stable(out_corner_a) && $stable(out_last), "stalled result changed")
  `RCM_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
  `RCM_ASSERT_SAME(a_no_req_during_out, out_valid, !in_ready, "ready while result pending")
  `RCM_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_last, !out_valid, "result after last")
  `RCM_ASSERT_SAME(a_tri_no_coord, out_valid && out_kind == KIND_TRI, out_coord_x == '0 && out_coord_y == '0, "triangle carries coordinates")

endmodule

bind raster_cell_map_to_triangles rcm_checker u_rcm_checker (.*);

// ===== tb/tb_raster_cell_map_to_triangles.sv =====
// testbench of the cell map mesher: directed maps, a wide map and random maps
// predicts vertices and triangles in its own model; needs rcm_pkg and the mesher top level
`timescale 1ns / 100ps

module tb_raster_cell_map_to_triangles;
  import rcm_pkg::*;

  // result of the mesher as the checker sees it
  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [IDX_W-1:0]   a;
    logic [IDX_W-1:0]   b;
    logic [IDX_W-1:0]   c;
    logic               last;
  } mesh_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [COORD_W-1:0] out_coord_x;
  logic [COORD_W-1:0] out_coord_y;
  logic [IDX_W-1:0]   out_corner_a;
  logic [IDX_W-1:0]   out_corner_b;
  logic [IDX_W-1:0]   out_corner_c;
  logic               out_last;

  raster_cell_map_to_triangles DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .out_corner_a(out_corner_a), .out_corner_b(out_corner_b),
    .out_corner_c(out_corner_c), .out_last(out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // idling knobs, in percent of cycles
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  // mesher state as the predictor keeps it
  logic [SIZE_W-1:0]  map_cols_reg = COLS_RESET;
  logic [SIZE_W-1:0]  map_rows_reg = ROWS_RESET;
  logic [SCALE_W-1:0] scale_reg = SCALE_RESET;
  logic [PIX_W-1:0]   pixel_line [MAX_COLUMNS];
  logic [VIX_W-1:0]   index_lines [2*MAX_COLUMNS];
  logic [PIX_W-1:0]   left_px = '0;
  logic [PIX_W-1:0]   upleft_px = '0;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  logic [IDX_W-1:0]   next_vertex = '0;

  mesh_res_t pending_results[$];
  int unsigned errors = 0;
  int unsigned cells_sent = 0;
  int unsigned vertices_seen = 0;
  int unsigned triangles_seen = 0;

  initial begin
    for (int i = 0; i < MAX_COLUMNS; i++) pixel_line[i] = '0;
    for (int i = 0; i < 2*MAX_COLUMNS; i++) index_lines[i] = '0;
  end

  // centroid coordinate in mm, 8 fraction bits, saturated to the output width
  function automatic logic [COORD_W-1:0] scaled_coord(input longint unsigned sum,
                                                      input longint unsigned weight);
    longint unsigned q;
    q = (sum * longint'(scale_reg)) / (weight * 256);
    return (q > 64'hFF_FFFF) ? {COORD_W{1'b1}} : q[COORD_W-1:0];
  endfunction

  function automatic mesh_res_t tri_res(input logic [VIX_W-1:0] a, input logic [VIX_W-1:0] b,
                                        input logic [VIX_W-1:0] c);
    mesh_res_t t;
    t = '0;
    t.kind = KIND_TRI;
    t.a = a[IDX_W-1:0];
    t.b = b[IDX_W-1:0];
    t.c = c[IDX_W-1:0];
    return t;
  endfunction

  // works out the results of one accepted cell and queues them
  function automatic void predict_cell(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned cols, rows, c, r, x, y, up, cur, cnt;
    logic [PIX_W-1:0] tl, tr, bl;
    logic [PIX_W-1:0] vals [4];
    int unsigned dx [4];
    int unsigned dy [4];
    longint unsigned sx, sy, w;
    logic [VIX_W-1:0] entry, v, n, b;
    mesh_res_t found[$];
    mesh_res_t vtx;
    cols = (map_cols_reg < 2) ? 2 : ((map_cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : map_cols_reg);
    rows = (map_rows_reg < 2) ? 2 : ((map_rows_reg > MAX_ROWS) ? MAX_ROWS : map_rows_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    if (c == 0 && r == 0) next_vertex = '0;
    tl = upleft_px;
    tr = pixel_line[c];
    bl = left_px;
    upleft_px = tr;
    pixel_line[c] = px;
    left_px = px;
    if (c >= 1 && r >= 1 && c < cols && r < rows) begin
      x = c - 1;
      y = r - 1;
      vals = '{tl, bl, px, tr};
      dx = '{0, 0, 1, 1};
      dy = '{0, 1, 1, 0};
      sx = 0; sy = 0; w = 0; cnt = 0;
      entry = '0;
      for (int i = 0; i < 4; i++) begin
        if (vals[i] > PIX_THRESH) begin
          sx += (x + dx[i]) * vals[i];
          sy += (y + dy[i]) * vals[i];
          w += vals[i];
          cnt++;
        end
      end
      if (cnt >= 2) begin
        entry = {1'b1, next_vertex};
        vtx = '0;
        vtx.kind = KIND_VERTEX;
        vtx.x = scaled_coord(sx, w);
        vtx.y = scaled_coord(sy, w);
        found.insert(found.size(), vtx);
        next_vertex = next_vertex + 1'b1;
      end
      index_lines[(y % 2) * MAX_COLUMNS + x] = entry;
      // triangles of the cell one row up and one column left
      if (c >= 2 && r >= 2) begin
        up = ((y - 1) % 2) * MAX_COLUMNS;
        cur = (y % 2) * MAX_COLUMNS;
        v = index_lines[up + x - 1];
        n = index_lines[up + x];
        b = index_lines[cur + x - 1];
        if (v[IDX_W] && n[IDX_W] && b[IDX_W]) begin
          found.insert(found.size(), tri_res(v, n, b));
          if (entry[IDX_W]) found.insert(found.size(), tri_res(n, entry, b));
        end else if (v[IDX_W] && n[IDX_W] && entry[IDX_W]) begin
          found.insert(found.size(), tri_res(v, n, entry));
        end else if (v[IDX_W] && !n[IDX_W] && b[IDX_W] && entry[IDX_W]) begin
          found.insert(found.size(), tri_res(v, b, entry));
        end else if (!v[IDX_W] && n[IDX_W] && b[IDX_W] && entry[IDX_W]) begin
          found.insert(found.size(), tri_res(n, entry, b));
        end
      end
    end
    // counters wrap at the clamped size
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_results.insert(pending_results.size(), found[i]);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // every accepted result against the oldest expectation
  always @(posedge clk) begin
    mesh_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_coord_x, out_coord_y, out_corner_a, out_corner_b,
             out_corner_c, out_last};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual kind %0d x %0d y %0d abc %0d %0d %0d last %0d",
                 $time, got.kind, got.x, got.y, got.a, got.b, got.c, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.kind == KIND_TRI) triangles_seen++;
        else vertices_seen++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected kind %0d x %0d y %0d abc %0d %0d %0d last %0d",
                   $time, want.kind, want.x, want.y, want.a, want.b, want.c, want.last);
          $display("%0t:           actual kind %0d x %0d y %0d abc %0d %0d %0d last %0d",
                   $time, got.kind, got.x, got.y, got.a, got.b, got.c, got.last);
        end
      end
    end
  end

  // one cell request; valid stays high into the next request when no gap is drawn
  task automatic send_cell(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    predict_cell(px, fs);
    cells_sent++;
  endtask

  // sender holds off until every result is out and the block has settled
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COLS: map_cols_reg = value[SIZE_W-1:0];
      REG_ROWS: map_rows_reg = value[SIZE_W-1:0];
      default:  scale_reg = value[SCALE_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_map(input int unsigned cols, input int unsigned rows,
                         input int unsigned scale);
    drain();
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_SCALE, scale);
  endtask

  // pixel mix that keeps vertices frequent but also hits the threshold edge
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0, 1:    return PIX_W'($urandom_range(16));
      2:       return PIX_W'(16 + $urandom_range(1));
      3:       return 8'd255;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // threshold edges, full scale, both wrap paths and the four corner cases
  task automatic test_directed;
    logic [PIX_W-1:0] grid_a [9];
    logic [PIX_W-1:0] grid_b [9];
    grid_a = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    grid_b = '{8'd0, 8'd17, 8'd200, 8'd16, 8'd255, 8'd0, 8'd128, 8'd17, 8'd64};
    set_map(3, 3, 65536);
    foreach (grid_a[i]) send_cell(grid_a[i], i == 0);
    // second map follows by wrapping, no frame start
    foreach (grid_b[i]) send_cell(grid_b[i], 1'b0);
    // sizes below range clamp to 2, scale at both extremes
    set_map(0, 1, 0);
    send_cell(8'd255, 1'b1);
    send_cell(8'd17, 1'b0);
    send_cell(8'd16, 1'b0);
    send_cell(8'd255, 1'b0);
    set_map(2, 2, 6553600);
    send_cell(8'd255, 1'b1);
    send_cell(8'd255, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd255, 1'b0);
  endtask

  // width clamped from above, then a long two-row strip at full scale
  task automatic test_wide_map;
    set_map(2047, 2047, 6553600);
    drain();
    write_reg(REG_ROWS, 2);
    for (int i = 0; i < 30; i++) send_cell(pick_pixel(), i == 0);
    set_map(100, 2, 6553600);
    for (int i = 0; i < 120; i++) send_cell(pick_pixel(), i == 0);
  endtask

  // random maps, mostly small, under one idling pattern
  task automatic test_random_maps(input int unsigned gap_pct, input int unsigned stall,
                                  input int unsigned budget);
    int unsigned cols, rows, cells, done;
    send_gap_pct = gap_pct;
    stall_pct = stall;
    done = 0;
    while (done < budget) begin
      cols = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(2, 8);
      rows = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(2, 8);
      if (cols > 12) rows = $urandom_range(2, 3);
      case ($urandom_range(3))
        0:       set_map(cols, rows, ($urandom_range(1) == 0) ? 0 : 6553600);
        default: set_map(cols, rows, $urandom_range(6553600));
      endcase
      cols = (cols < 2) ? 2 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
      rows = (rows < 2) ? 2 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
      cells = cols * rows;
      // large maps are only entered, never finished
      if (cells > 60) cells = 30 + $urandom_range(30);
      // occasionally run past the end so the map wraps onto itself
      if ($urandom_range(4) == 0) cells += cols * rows <= 60 ? cols * rows : 0;
      for (int i = 0; i < cells; i++) begin
        // a stray frame start cuts the map short now and then
        send_cell(pick_pixel(), i == 0 || $urandom_range(80) == 0);
      end
      done += cells;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_wide_map();
    test_random_maps(15, 75, 55);
    test_random_maps(75, 15, 55);
    test_random_maps(0, 0, 55);
    drain();
    $display("sent %0d cells over clamped, wrapped and wide maps", cells_sent);
    $display("checked %0d vertices and %0d triangles", vertices_seen, triangles_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rcm_pkg.sv
rtl/rcm_ram.sv
rtl/rcm_div.sv
rtl/rcm_datapath.sv
rtl/rcm_ctrl.sv
rtl/raster_cell_map_to_triangles.sv
rtl/rcm_checker.sv
tb/tb_raster_cell_map_to_triangles.sv
